/* rtl/core/ndm_pkg.sv */
`default_nettype none
package ndm_pkg;

	// item opcodes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// view modes
	localparam logic VIEW_CLOCK = 1'b0;
	localparam logic VIEW_TEMP  = 1'b1;

	// edit modes
	localparam logic [1:0] EDIT_NONE = 2'd0;
	localparam logic [1:0] EDIT_HOUR = 2'd1;
	localparam logic [1:0] EDIT_MIN  = 2'd2;

	// anode line of each digit
	localparam logic [3:0] ANODE_THOUSANDS = 4'b0100;
	localparam logic [3:0] ANODE_HUNDREDS  = 4'b0010;
	localparam logic [3:0] ANODE_TENS      = 4'b1000;
	localparam logic [3:0] ANODE_UNITS     = 4'b0001;

	// digit phases of the scan; later phases drive the colon
	localparam int PH_THOUSANDS = 0;
	localparam int PH_HUNDREDS  = 1;
	localparam int PH_TENS      = 2;
	localparam int PH_UNITS     = 3;

	// largest digit the decoder accepts
	localparam logic [6:0] DIGIT_MAX = 7'd9;

	typedef struct packed {
		logic [6:0] thousands;
		logic [3:0] hundreds;
		logic [3:0] tens;
		logic [3:0] units;
	} digits_t;

endpackage
`default_nettype wire

/* rtl/core/ndm_item_if.sv */
`default_nettype none
interface ndm_item_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [15:0] number;
	logic        view_mode;
	logic [1:0]  edit_mode;
	logic        blink_level;

	modport source (output valid, opcode, number, view_mode, edit_mode, blink_level,
		input ready);
	modport sink (input valid, opcode, number, view_mode, edit_mode, blink_level,
		output ready);
endinterface
`default_nettype wire

/* rtl/core/ndm_result_if.sv */
`default_nettype none
interface ndm_result_if;
	logic       valid;
	logic       ready;
	logic [3:0] anode_enables;
	logic [3:0] decoder_code;
	logic       colon_led;

	modport source (output valid, anode_enables, decoder_code, colon_led, input ready);
	modport sink (input valid, anode_enables, decoder_code, colon_led, output ready);
endinterface
`default_nettype wire

/* rtl/core/nixie_display_multiplexer.sv */
// An accepted item's result transaction is registered and presented in the cycle after acceptance.
// Throughput: one item per cycle; item.ready drops only while a result is
// held and result.ready is low.
// Reset (arst_n low): scan phase, digits, view, output registers and the
// result valid flag clear; the first result after reset follows the first item.
`default_nettype none
module nixie_display_multiplexer
	import ndm_pkg::*;
#(
	parameter int SCAN_PHASES = 5
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	ndm_item_if.sink     item,
	ndm_result_if.source result
);

	localparam int PHASE_W = $clog2(SCAN_PHASES);
	localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(SCAN_PHASES - 1);

	// Scan state and latched display data.
	logic [PHASE_W-1:0] phase_q;
	logic [3:0]         low_digits_q [3];  // [0] units, [1] tens, [2] hundreds
	logic [6:0]         thousands_q;
	logic               view_q;

	// Output registers; they are also the payload of the result transaction.
	logic [3:0] anode_q;
	logic [3:0] code_q;
	logic       colon_q;
	logic       res_valid_q;

	logic               accept;
	digits_t            digits;
	logic               hour_blank;
	logic               min_blank;
	logic [PHASE_W-1:0] ph;
	logic [6:0]         sel_digit;
	logic [3:0]         sel_anode;
	logic               sel_blank;
	logic               is_digit_phase;
	logic [3:0]         anode_d;
	logic [3:0]         code_d;
	logic               colon_d;
	logic [PHASE_W-1:0] phase_d;

	// A new item is taken whenever the result slot is empty or being drained.
	assign item.ready = !res_valid_q || result.ready;
	assign accept     = item.valid && item.ready;

	// Decimal split of the load value, registered into the digit latches.
	ndm_digit_split u_split (
		.number (item.number),
		.digits (digits)
	);

	// Blanking during edit: hours or minutes pair goes dark on the low half
	// of the blink wave. Edit codes zero and three blank nothing.
	assign hour_blank = (item.edit_mode == EDIT_HOUR) && !item.blink_level;
	assign min_blank  = (item.edit_mode == EDIT_MIN) && !item.blink_level;

	// An out-of-range phase behaves as the colon phase and wraps to zero.
	assign ph = (phase_q > PHASE_LAST) ? PHASE_LAST : phase_q;

	// Digit mux for the current phase.
	always_comb begin
		is_digit_phase = 1'b1;
		sel_digit      = 7'd0;
		sel_anode      = ANODE_THOUSANDS;
		sel_blank      = 1'b0;
		case (int'(ph))
			PH_THOUSANDS: begin
				sel_digit = thousands_q;
				sel_anode = ANODE_THOUSANDS;
				sel_blank = hour_blank;
			end
			PH_HUNDREDS: begin
				sel_digit = {3'b000, low_digits_q[2]};
				sel_anode = ANODE_HUNDREDS;
				sel_blank = hour_blank;
			end
			PH_TENS: begin
				sel_digit = {3'b000, low_digits_q[1]};
				sel_anode = ANODE_TENS;
				sel_blank = min_blank;
			end
			PH_UNITS: begin
				sel_digit = {3'b000, low_digits_q[0]};
				sel_anode = ANODE_UNITS;
				// units digit is never lit in temperature view
				sel_blank = min_blank || (view_q == VIEW_TEMP);
			end
			default: begin
				is_digit_phase = 1'b0;
			end
		endcase
	end

	// Next output and phase values for a tick. Loads leave them alone.
	always_comb begin
		anode_d = anode_q;
		code_d  = code_q;
		colon_d = colon_q;
		if (is_digit_phase) begin
			anode_d = sel_blank ? 4'b0000 : sel_anode;
			// codes above nine would light nothing sensible; keep the last one
			if (sel_digit <= DIGIT_MAX) begin
				code_d = sel_digit[3:0];
			end
		end else begin
			// colon follows blink; in temperature view it only ever sets
			if (item.blink_level) begin
				colon_d = 1'b1;
			end else if (view_q != VIEW_TEMP) begin
				colon_d = 1'b0;
			end
		end
		phase_d = (ph >= PHASE_LAST) ? '0 : ph + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= '0;
			low_digits_q[0] <= '0;
			low_digits_q[1] <= '0;
			low_digits_q[2] <= '0;
			thousands_q     <= '0;
			view_q          <= VIEW_CLOCK;
			anode_q         <= '0;
			code_q          <= '0;
			colon_q         <= 1'b0;
		end else if (accept) begin
			if (item.opcode == OP_LOAD) begin
				view_q          <= item.view_mode;
				low_digits_q[0] <= digits.units;
				low_digits_q[1] <= digits.tens;
				low_digits_q[2] <= digits.hundreds;
				thousands_q     <= digits.thousands;
			end else begin
				phase_q <= phase_d;
				anode_q <= anode_d;
				code_q  <= code_d;
				colon_q <= colon_d;
			end
		end
	end

	// Every item yields exactly one result transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.anode_enables = anode_q;
	assign result.decoder_code  = code_q;
	assign result.colon_led     = colon_q;

endmodule
`default_nettype wire

/* rtl/core/ndm_digit_split.sv */
`default_nettype none
// Splits a 16-bit value into decimal digits; reciprocal multiplies, no divider.
module ndm_digit_split
	import ndm_pkg::*;
(
	input  wire logic [15:0] number,
	output digits_t          digits
);

	logic [32:0] prod1000;
	logic [32:0] prod100;
	logic [31:0] prod10;
	logic [6:0]  q1000;
	logic [9:0]  q100;
	logic [12:0] q10;
	logic [9:0]  q1000x10;
	logic [12:0] q100x10;
	logic [15:0] q10x10;
	logic [9:0]  hund_w;
	logic [12:0] tens_w;
	logic [15:0] units_w;

	// floor(n/d) = (n * ceil(2^s/d)) >> s, exact for all 16-bit n
	assign prod1000 = {1'b0, number} * 33'd67109;
	assign prod100  = {1'b0, number} * 33'd83887;
	assign prod10   = {16'd0, number} * 32'd52429;

	assign q1000 = prod1000[32:26];
	assign q100  = prod100[32:23];
	assign q10   = prod10[31:19];

	assign q1000x10 = {q1000, 3'b000} + {2'b00, q1000, 1'b0};
	assign q100x10  = {q100, 3'b000} + {2'b00, q100, 1'b0};
	assign q10x10   = {q10, 3'b000} + {2'b00, q10, 1'b0};

	assign hund_w  = q100 - q1000x10;
	assign tens_w  = q10 - q100x10;
	assign units_w = number - q10x10;

	assign digits.thousands = q1000;
	assign digits.hundreds  = hund_w[3:0];
	assign digits.tens      = tens_w[3:0];
	assign digits.units     = units_w[3:0];

endmodule
`default_nettype wire
